// ----- sv/lsa_fletcher_checksum_unit_assert.svh -----
// ---------------------------------------------------------------------------
// LSA checksum unit assertion macros
// Concurrent checks on clk_i, disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef LSA_FLETCHER_CHECKSUM_UNIT_ASSERT_SVH
`define LSA_FLETCHER_CHECKSUM_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// cond |-> prop in the same cycle
`define LSA_CK_ASSERT_SAME(name, cond, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error("lsa checksum assertion failed");
// cond |=> prop in the next cycle
`define LSA_CK_ASSERT_NEXT(name, cond, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error("lsa checksum assertion failed");
`else
`define LSA_CK_ASSERT_SAME(name, cond, prop)
`define LSA_CK_ASSERT_NEXT(name, cond, prop)
`endif

`endif

// ----- sv/lsa_ck_pkg.sv -----
// ---------------------------------------------------------------------------
// LSA checksum package
// Shared constants, job type and mod-255 helper.
// ---------------------------------------------------------------------------
package lsa_ck_pkg;

  localparam int unsigned MaxLengthDef = 65535;
  localparam int unsigned FifoDepthDef = 4;

  localparam int unsigned MinLength  = 20;
  localparam int unsigned SkipBytes  = 2;
  localparam int unsigned CkPosHi    = 16;
  localparam int unsigned CkPosLo    = 17;
  localparam int unsigned SpanOffset = 17;  // skipped bytes plus checksum span offset
  localparam int unsigned DiffW      = 16;

  typedef struct packed {
    logic [7:0]       c0;
    logic [7:0]       c1;
    logic [DiffW-1:0] diff;  // length - 17
    logic             err;
  } job_t;

  // reduce a value in 0..510 modulo 255
  function automatic logic [7:0] mod255_9(input logic [8:0] v);
    logic [8:0] r;
    begin
      if (v >= 9'd510) begin
        r = v - 9'd510;
      end else if (v >= 9'd255) begin
        r = v - 9'd255;
      end else begin
        r = v;
      end
      mod255_9 = r[7:0];
    end
  endfunction

  // 16-bit value modulo 255: 256 is 1 mod 255, so fold the bytes
  function automatic logic [7:0] mod255_16(input logic [15:0] v);
    logic [8:0] s;
    begin
      s = {1'b0, v[15:8]} + {1'b0, v[7:0]};
      mod255_16 = mod255_9(s);
    end
  endfunction

endpackage

// ----- sv/lsa_ck_front.sv -----
// ---------------------------------------------------------------------------
// LSA checksum front end
// Accepts bytes, keeps the running sums and byte count, queues a job per LSA.
// ---------------------------------------------------------------------------
module lsa_ck_front import lsa_ck_pkg::*; #(
  parameter int unsigned MAX_LENGTH = MaxLengthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_valid_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  input  logic       queue_full_i,
  output logic       byte_ready_o,
  output logic       job_push_o,
  output job_t       job_o
);

  localparam int unsigned CntW = $clog2(MAX_LENGTH + 2);

  logic [7:0]      c0_q, c0_d, c1_q, c1_d;
  logic [CntW-1:0] pos_q, pos_d;
  logic [7:0]      b;
  logic            take;

  assign byte_ready_o = !queue_full_i;
  assign take         = byte_valid_i && byte_ready_o;

  always_comb begin
    b    = byte_i;
    c0_d = c0_q;
    c1_d = c1_q;
    if (pos_q == CntW'(CkPosHi) || pos_q == CntW'(CkPosLo)) begin
      b = 8'd0;
    end
    if (pos_q >= CntW'(SkipBytes)) begin
      c0_d = mod255_9({1'b0, c0_q} + {1'b0, b});
      c1_d = mod255_9({1'b0, c1_q} + {1'b0, c0_d});
    end
    // count holds at MAX_LENGTH+1
    pos_d = (pos_q == CntW'(MAX_LENGTH + 1)) ? pos_q : pos_q + CntW'(1);
  end

  assign job_push_o = take && last_i;
  assign job_o.c0   = c0_d;
  assign job_o.c1   = c1_d;
  assign job_o.diff = DiffW'(pos_d - CntW'(SpanOffset));
  assign job_o.err  = (pos_d < CntW'(MinLength)) || (pos_d > CntW'(MAX_LENGTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c0_q  <= '0;
      c1_q  <= '0;
      pos_q <= '0;
    end else if (take) begin
      if (last_i) begin
        c0_q  <= '0;
        c1_q  <= '0;
        pos_q <= '0;
      end else begin
        c0_q  <= c0_d;
        c1_q  <= c1_d;
        pos_q <= pos_d;
      end
    end
  end

endmodule

// ----- sv/lsa_ck_fifo.sv -----
// ---------------------------------------------------------------------------
// LSA checksum job queue
// Small register queue between front end and back end.
// ---------------------------------------------------------------------------
module lsa_ck_fifo import lsa_ck_pkg::*; #(
  parameter int unsigned DEPTH = FifoDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  input  logic pop_i,
  output logic full_o,
  output logic valid_o,
  output job_t data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  job_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ----- sv/lsa_ck_back.sv -----
// ---------------------------------------------------------------------------
// LSA checksum back end
// Pipeline computing x and y from a queued job, with an output register.
// ---------------------------------------------------------------------------
module lsa_ck_back import lsa_ck_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        job_valid_i,
  input  job_t        job_i,
  output logic        job_pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] out_check_o,
  output logic        out_err_o
);

  logic        en;
  // stage 1: length term mod 255
  logic        v1_q;
  logic [7:0]  c0_1_q, c1_1_q, m1_q;
  logic        err1_q;
  // stage 2: product
  logic        v2_q;
  logic [7:0]  c0_2_q, c1_2_q;
  logic [15:0] p2_q;
  logic        err2_q;
  // stage 3: x
  logic        v3_q;
  logic [7:0]  c0_3_q, x3_q, x3_d;
  logic        err3_q;
  // output register
  logic        ov_q;
  logic [15:0] oc_q, oc_d;
  logic        oe_q;
  logic [7:0]  pm, y;

  assign en        = !ov_q || out_ready_i;
  assign job_pop_o = en;

  always_comb begin
    pm   = mod255_16(p2_q);
    x3_d = mod255_9({1'b0, pm} + 9'd255 - {1'b0, c1_2_q});
    y    = mod255_9(9'd510 - {1'b0, c0_3_q} - {1'b0, x3_q});
    oc_d = err3_q ? 16'd0 : {x3_q, y};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (en) begin
      v1_q <= job_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      ov_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c0_1_q <= job_i.c0;
      c1_1_q <= job_i.c1;
      m1_q   <= mod255_16(job_i.diff);
      err1_q <= job_i.err;
      c0_2_q <= c0_1_q;
      c1_2_q <= c1_1_q;
      p2_q   <= {8'd0, m1_q} * {8'd0, c0_1_q};
      err2_q <= err1_q;
      c0_3_q <= c0_2_q;
      x3_q   <= x3_d;
      err3_q <= err2_q;
      oc_q   <= oc_d;
      oe_q   <= err3_q;
    end
  end

  assign out_valid_o = ov_q;
  assign out_check_o = oc_q;
  assign out_err_o   = oe_q;

endmodule

// ----- sv/lsa_fletcher_checksum_unit.sv -----
// Path: the last byte's job is queued, then runs through the back-end pipeline.
// Throughput: one byte per cycle; the front end stalls only when the job queue
// (FIFO_DEPTH entries) is full, which happens while the result port is held.
// Reset: rst_ni asynchronous, active low; clears sums, count, queue and
// pipeline valids. No start-up pass.
// ---------------------------------------------------------------------------
// LSA Fletcher checksum unit
// Streams LSA bytes, gives the ISO 8473 check value per advertisement.
// ---------------------------------------------------------------------------
`include "lsa_fletcher_checksum_unit_assert.svh"

module lsa_fletcher_checksum_unit import lsa_ck_pkg::*; #(
  parameter int unsigned MAX_LENGTH = MaxLengthDef,
  parameter int unsigned FIFO_DEPTH = FifoDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] check_value
  output logic        m_axis_tuser    // [0] length_error
);

  logic q_full, q_valid, q_push, q_pop;
  job_t q_in, q_out;

  lsa_ck_front #(
    .MAX_LENGTH(MAX_LENGTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_valid_i(s_axis_tvalid),
    .byte_i      (s_axis_tdata),
    .last_i      (s_axis_tlast),
    .queue_full_i(q_full),
    .byte_ready_o(s_axis_tready),
    .job_push_o  (q_push),
    .job_o       (q_in)
  );

  lsa_ck_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_in),
    .pop_i  (q_pop),
    .full_o (q_full),
    .valid_o(q_valid),
    .data_o (q_out)
  );

  lsa_ck_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(q_valid),
    .job_i      (q_out),
    .job_pop_o  (q_pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_check_o(m_axis_tdata),
    .out_err_o  (m_axis_tuser)
  );

  // a length error always carries a zero check value
  `LSA_CK_ASSERT_SAME(a_err_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 16'd0)
  // both check bytes are reduced into 0..254
  `LSA_CK_ASSERT_SAME(a_bytes_reduced, m_axis_tvalid,
                      m_axis_tdata[15:8] != 8'hff && m_axis_tdata[7:0] != 8'hff)
  // a queued job is never lost: a push into the queue leaves it non-empty
  `LSA_CK_ASSERT_NEXT(a_push_seen, q_push && !q_full, q_valid)

endmodule
